@@ src/p2ur_pkg.sv @@
// ----------------------------------------------------------------------------
// p2ur_pkg: shared constants and fixed-point helpers
// Register codes, default widths and the saturating arithmetic used by the
// stages of the pixel-to-ray pipeline.
// ----------------------------------------------------------------------------
package p2ur_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int NEWTON_STEPS_DEF = 5;
    localparam int WIDE             = 128;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int PIX_W            = 16;
    localparam int PIX_FRAC         = 4;
    localparam int GAIN_W           = 32;
    localparam int REG_W            = 32;
    localparam int REG_FRAC         = 28;
    localparam int RAY_W            = 32;

    typedef logic signed [WIDE-1:0] t_wide;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_COL,
        CFG_OFFSET_COL,
        CFG_GAIN_ROW,
        CFG_OFFSET_ROW,
        CFG_COEF_SQUARE,
        CFG_COEF_CUBE,
        CFG_COEF_QUARTIC,
        CFG_LENS_SHIFT
    } t_cfg_idx;

    function automatic t_wide pow2(input int n);
        t_wide one;
        one = t_wide'(1);
        return one <<< n;
    endfunction

    // Clamp to the signed range of a w-bit word.
    function automatic t_wide sat_to(input t_wide v, input int w);
        t_wide hi;
        t_wide lo;
        hi = pow2(w - 1) - t_wide'(1);
        lo = -pow2(w - 1);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Round a product magnitude to nearest (ties away from zero), apply the
    // sign and saturate to a w-bit word.
    function automatic t_wide qmul_fin(input logic neg, input t_wide m, input int frac,
                                       input int w);
        t_wide t;
        t_wide lim;
        t_wide v;
        t   = (m + pow2(frac - 1)) >>> frac;
        lim = neg ? pow2(w - 1) : pow2(w - 1) - t_wide'(1);
        v   = (t > lim) ? lim : t;
        return neg ? -v : v;
    endfunction

    // Q4.28 register value to Q4.frac.
    function automatic t_wide from_q28(input logic [REG_W-1:0] x, input int frac);
        t_wide v;
        v = t_wide'($signed(x));
        if (frac >= REG_FRAC) return v <<< (frac - REG_FRAC);
        return v >>> (REG_FRAC - frac);
    endfunction

    // Q4.frac to Q4.28, round half up, saturated to 32 bits.
    function automatic t_wide to_q28(input t_wide x, input int frac);
        t_wide v;
        if (frac > REG_FRAC) v = (x + pow2(frac - REG_FRAC - 1)) >>> (frac - REG_FRAC);
        else v = x <<< (REG_FRAC - frac);
        return sat_to(v, RAY_W);
    endfunction

endpackage

@@ src/p2ur_if.sv @@
// ----------------------------------------------------------------------------
// p2ur_if: request channels of the pixel-to-ray block
// Pixel requests in and ray requests out, each with valid and ready.
// ----------------------------------------------------------------------------
interface p2ur_pixel_if import p2ur_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface p2ur_ray_if import p2ur_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAY_W-1:0] ray_horiz;
    logic signed [RAY_W-1:0] ray_vert;

    modport source (output valid, output ray_horiz, output ray_vert, input ready);
    modport sink   (input valid, input ray_horiz, input ray_vert, output ready);
endinterface

@@ src/p2ur_mul_cell.sv @@
// ----------------------------------------------------------------------------
// p2ur_mul_cell: registered magnitude multiplier cell
// Multiplies the magnitudes of signed operand pairs and carries the side data.
// ----------------------------------------------------------------------------
module p2ur_mul_cell import p2ur_pkg::*; #(
    parameter int W     = COORD_WIDTH_DEF,
    parameter int SW    = 1,
    parameter int LANES = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [SW-1:0]       i_side,
    input  logic signed [W-1:0] i_a [LANES],
    input  logic signed [W-1:0] i_b [LANES],
    output logic                o_vld,
    output logic [SW-1:0]       o_side,
    output logic [2*W-1:0]      o_mag [LANES]
);

    logic           r_vld;
    logic [SW-1:0]  r_side;
    logic [2*W-1:0] r_mag [LANES];
    logic [2*W-1:0] n_mag [LANES];

    // The magnitude of the most negative value needs all W bits, so it is
    // widened as an unsigned number.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_mag[l] = (2*W)'($unsigned(i_a[l][W-1] ? W'(-i_a[l]) : W'(i_a[l])))
                     * (2*W)'($unsigned(i_b[l][W-1] ? W'(-i_b[l]) : W'(i_b[l])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_side <= i_side;
            r_mag  <= n_mag;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_mag  = r_mag;

endmodule

@@ src/p2ur_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// p2ur_sqrt_cell: one root bit of a restoring square root
// Takes two radicand bits, tries the next root bit and hands on the remainder.
// ----------------------------------------------------------------------------
module p2ur_sqrt_cell import p2ur_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [SW-1:0]  i_side,
    input  logic [2*W-1:0] i_s,
    input  logic [W+1:0]   i_rem,
    input  logic [W-1:0]   i_root,
    output logic           o_vld,
    output logic [SW-1:0]  o_side,
    output logic [2*W-1:0] o_s,
    output logic [W+1:0]   o_rem,
    output logic [W-1:0]   o_root
);

    logic           r_vld;
    logic [SW-1:0]  r_side;
    logic [2*W-1:0] r_s;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [W+3:0]   rem_sh;
    logic [W+3:0]   trial;
    logic [W+1:0]   n_rem;
    logic [W-1:0]   n_root;

    always_comb begin
        rem_sh = {i_rem, i_s[2*W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = (W+2)'(rem_sh - trial);
            n_root = {i_root[W-2:0], 1'b1};
        end else begin
            n_rem  = (W+2)'(rem_sh);
            n_root = {i_root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_side <= i_side;
            r_s    <= {i_s[2*W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_s    = r_s;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ src/p2ur_div_cell.sv @@
// ----------------------------------------------------------------------------
// p2ur_div_cell: one quotient bit of a restoring divider
// Shifts in the next dividend bit, subtracts the divisor where it fits.
// ----------------------------------------------------------------------------
module p2ur_div_cell import p2ur_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [SW-1:0] i_side,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_quo,
    input  logic          i_ovf,
    output logic          o_vld,
    output logic [SW-1:0] o_side,
    output logic [W-1:0]  o_num,
    output logic [W-1:0]  o_den,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_quo,
    output logic          o_ovf
);

    logic          r_vld;
    logic [SW-1:0] r_side;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic          r_ovf;
    logic [W:0]    rem2;
    logic [W-1:0]  n_rem;
    logic          qbit;

    always_comb begin
        rem2 = {i_rem, i_num[W-1]};
        if (rem2 >= {1'b0, i_den}) begin
            n_rem = W'(rem2 - {1'b0, i_den});
            qbit  = 1'b1;
        end else begin
            n_rem = W'(rem2);
            qbit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_side <= i_side;
            r_num  <= {i_num[W-2:0], 1'b0};
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_quo  <= {i_quo[W-2:0], qbit};
            // A bit pushed out of the top means the quotient needs more than W bits.
            r_ovf  <= i_ovf | i_quo[W-1];
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

@@ src/p2ur_newton.sv @@
// ----------------------------------------------------------------------------
// p2ur_newton: one Newton step on the undistortion factor
// Evaluates the distortion polynomial and its derivative at c*r, divides and
// updates c, as a chain of multiplier and divider cells.
// ----------------------------------------------------------------------------
module p2ur_newton import p2ur_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic signed [W-1:0] i_k2,
    input  logic signed [W-1:0] i_k3,
    input  logic signed [W-1:0] i_k4,
    input  logic signed [W-1:0] i_d2,
    input  logic signed [W-1:0] i_d3,
    input  logic signed [W-1:0] i_d4,
    input  logic                i_vld,
    input  logic [SW-1:0]       i_side,
    input  logic signed [W-1:0] i_r,
    input  logic signed [W-1:0] i_c,
    output logic                o_vld,
    output logic [SW-1:0]       o_side,
    output logic signed [W-1:0] o_r,
    output logic signed [W-1:0] o_c
);

    localparam int F  = W - 4;
    localparam int DW = W + F;
    localparam logic signed [W-1:0] ONE = {3'b000, 1'b1, {F{1'b0}}};

    typedef struct packed {
        logic [SW-1:0]       outer;
        logic signed [W-1:0] r;
        logic signed [W-1:0] c;
        logic signed [W-1:0] r1;
        logic signed [W-1:0] pa;
        logic signed [W-1:0] pb;
    } t_ctx;

    typedef struct packed {
        t_ctx ctx;
        logic neg;
        logic zero;
    } t_dside;

    localparam int CW = $bits(t_ctx);
    localparam int XW = CW + 2;
    localparam int DS = $bits(t_dside);

    function automatic logic signed [W-1:0] qf(input logic neg, input logic [2*W-1:0] m);
        return W'(qmul_fin(neg, t_wide'(m), F, W));
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return W'(sat_to(t_wide'(a) + t_wide'(b), W));
    endfunction

    // Multiplier chain: six cells, the side word is {context, lane signs}.
    logic                vm [7];
    logic [XW-1:0]       xs [7];
    logic signed [W-1:0] a1 [1], b1 [1], a6 [1], b6 [1];
    logic signed [W-1:0] a2 [2], b2 [2], a3 [2], b3 [2], a4 [2], b4 [2], a5 [2], b5 [2];
    logic [2*W-1:0]      m1 [1], m6 [1];
    logic [2*W-1:0]      m2 [2], m3 [2], m4 [2], m5 [2];
    t_ctx                c0, c1, c2, c3, c4, c5;

    always_comb begin
        c0       = '0;
        c0.outer = i_side;
        c0.r     = i_r;
        c0.c     = i_c;
        a1[0]    = c0.c;
        b1[0]    = c0.r;

        c1       = xs[1][XW-1:2];
        c1.r1    = qf(xs[1][0], m1[0]);
        a2[0]    = i_k4;
        a2[1]    = i_d4;
        b2[0]    = c1.r1;
        b2[1]    = c1.r1;

        c2       = xs[3][XW-1:2];
        c2.pa    = sadd(i_k3, qf(xs[3][0], m2[0]));
        c2.pb    = sadd(i_d3, qf(xs[3][1], m2[1]));
        a3[0]    = c2.pa;
        a3[1]    = c2.pb;
        b3[0]    = c2.r1;
        b3[1]    = c2.r1;

        c3       = xs[4][XW-1:2];
        c3.pa    = sadd(i_k2, qf(xs[4][0], m3[0]));
        c3.pb    = sadd(i_d2, qf(xs[4][1], m3[1]));
        a4[0]    = c3.pa;
        a4[1]    = c3.pb;
        b4[0]    = c3.r1;
        b4[1]    = c3.r1;

        c4       = xs[5][XW-1:2];
        c4.pa    = qf(xs[5][0], m4[0]);
        c4.pb    = qf(xs[5][1], m4[1]);
        a5[0]    = c4.pa;
        a5[1]    = c4.pb;
        b5[0]    = c4.r1;
        b5[1]    = c4.r1;

        c5       = xs[6][XW-1:2];
        c5.pa    = sadd(ONE, qf(xs[6][0], m5[0]));
        c5.pb    = sadd(ONE, qf(xs[6][1], m5[1]));
        a6[0]    = c5.c;
        b6[0]    = c5.pa;
    end

    assign xs[0] = {c0, 1'b0, c0.c[W-1] ^ c0.r[W-1]};
    assign xs[2] = {c1, i_d4[W-1] ^ c1.r1[W-1], i_k4[W-1] ^ c1.r1[W-1]};

    // Cell k takes the side word of the stage before it.
    logic [XW-1:0] xin2, xin3, xin4, xin5;
    logic [XW-1:0] xo1, xo2, xo3, xo4, xo5, xo6;

    assign xin2 = {c2, c2.pb[W-1] ^ c2.r1[W-1], c2.pa[W-1] ^ c2.r1[W-1]};
    assign xin3 = {c3, c3.pb[W-1] ^ c3.r1[W-1], c3.pa[W-1] ^ c3.r1[W-1]};
    assign xin4 = {c4, c4.pb[W-1] ^ c4.r1[W-1], c4.pa[W-1] ^ c4.r1[W-1]};
    assign xin5 = {c5, 1'b0, c5.c[W-1] ^ c5.pa[W-1]};

    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(1)) u_m1 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[0]), .i_side(xs[0]), .i_a(a1), .i_b(b1),
        .o_vld(vm[1]), .o_side(xo1), .o_mag(m1));
    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(2)) u_m2 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[1]), .i_side(xs[2]), .i_a(a2), .i_b(b2),
        .o_vld(vm[2]), .o_side(xo2), .o_mag(m2));
    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(2)) u_m3 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[2]), .i_side(xin2), .i_a(a3), .i_b(b3),
        .o_vld(vm[3]), .o_side(xo3), .o_mag(m3));
    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(2)) u_m4 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[3]), .i_side(xin3), .i_a(a4), .i_b(b4),
        .o_vld(vm[4]), .o_side(xo4), .o_mag(m4));
    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(2)) u_m5 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[4]), .i_side(xin4), .i_a(a5), .i_b(b5),
        .o_vld(vm[5]), .o_side(xo5), .o_mag(m5));
    p2ur_mul_cell #(.W(W), .SW(XW), .LANES(1)) u_m6 (
        .i_clk, .i_rst_n, .i_en, .i_vld(vm[5]), .i_side(xin5), .i_a(a6), .i_b(b6),
        .o_vld(vm[6]), .o_side(xo6), .o_mag(m6));

    assign xs[1] = xo1;
    assign xs[3] = xo2;
    assign xs[4] = xo3;
    assign xs[5] = xo4;
    assign xs[6] = xo5;
    assign vm[0] = i_vld;

    // Numerator c*f(c*r) - 1 and derivative, made into magnitudes for the divider.
    t_ctx                cq;
    logic signed [W-1:0] nq;
    t_dside              n_p_side;
    logic                r_p_vld;
    t_dside              r_p_side;
    logic [W-1:0]        r_p_num;
    logic [W-1:0]        r_p_den;

    always_comb begin
        cq       = xo6[XW-1:2];
        nq       = W'(sat_to(t_wide'(qf(xo6[0], m6[0])) - t_wide'(ONE), W));
        n_p_side.ctx  = cq;
        n_p_side.neg  = nq[W-1] ^ cq.pb[W-1];
        n_p_side.zero = (cq.pb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= vm[6];
        end
        if (i_en) begin
            r_p_side <= n_p_side;
            r_p_num  <= nq[W-1] ? W'(-nq) : W'(nq);
            r_p_den  <= cq.pb[W-1] ? W'(-cq.pb) : W'(cq.pb);
        end
    end

    // Divider chain: one quotient bit per cell over all W+F dividend bits.
    logic          dv_vld  [DW+1];
    logic [DS-1:0] dv_side [DW+1];
    logic [W-1:0]  dv_num  [DW+1];
    logic [W-1:0]  dv_den  [DW+1];
    logic [W-1:0]  dv_rem  [DW+1];
    logic [W-1:0]  dv_quo  [DW+1];
    logic          dv_ovf  [DW+1];

    assign dv_vld[0]  = r_p_vld;
    assign dv_side[0] = r_p_side;
    assign dv_num[0]  = r_p_num;
    assign dv_den[0]  = r_p_den;
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_ovf[0]  = 1'b0;

    for (genvar g = 0; g < DW; g++) begin : g_div
        p2ur_div_cell #(.W(W), .SW(DS)) u_cell (
            .i_clk, .i_rst_n, .i_en,
            .i_vld(dv_vld[g]), .i_side(dv_side[g]), .i_num(dv_num[g]), .i_den(dv_den[g]),
            .i_rem(dv_rem[g]), .i_quo(dv_quo[g]), .i_ovf(dv_ovf[g]),
            .o_vld(dv_vld[g+1]), .o_side(dv_side[g+1]), .o_num(dv_num[g+1]),
            .o_den(dv_den[g+1]), .o_rem(dv_rem[g+1]), .o_quo(dv_quo[g+1]),
            .o_ovf(dv_ovf[g+1]));
    end

    // Saturate the quotient, then c = c - step; a zero derivative leaves c alone.
    t_dside              ds;
    logic [W-1:0]        lim;
    logic [W-1:0]        qmag;
    logic signed [W-1:0] step;
    logic                r_u_vld;
    logic [SW-1:0]       r_u_outer;
    logic signed [W-1:0] r_u_r;
    logic signed [W-1:0] r_u_c;

    always_comb begin
        ds   = dv_side[DW];
        lim  = ds.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        qmag = (dv_ovf[DW] || dv_quo[DW] > lim) ? lim : dv_quo[DW];
        if (ds.zero) step = '0;
        else step = ds.neg ? -$signed(qmag) : $signed(qmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
        end else if (i_en) begin
            r_u_vld <= dv_vld[DW];
        end
        if (i_en) begin
            r_u_outer <= ds.ctx.outer;
            r_u_r     <= ds.ctx.r;
            r_u_c     <= W'(sat_to(t_wide'(ds.ctx.c) - t_wide'(step), W));
        end
    end

    assign o_vld  = r_u_vld;
    assign o_side = r_u_outer;
    assign o_r    = r_u_r;
    assign o_c    = r_u_c;

endmodule

@@ src/pixel_to_undistorted_ray_core.sv @@
// ----------------------------------------------------------------------------
// pixel_to_undistorted_ray_core: pixel position to undistorted image-plane ray
// Gain and offset per axis, radial undistortion by Newton iteration, output
// in saturated Q4.28.
// ----------------------------------------------------------------------------
// The block accepts one pixel request per clock while the pipeline is not
// held, and returns one ray request for each, in order. W below is
// COORD_WIDTH. The pipeline is built mostly from bit-serial units laid out
// as rows of cells: the square root spends one cell per root bit (W cells),
// and each of the NEWTON_STEPS Newton steps holds six multiplier cells, a
// preparation register, a restoring divider of one cell per quotient bit
// (2*W - 4 cells) and an update register. The whole pipeline advances
// together; it holds only while a finished ray request is waiting at the
// output and the sink is not ready, and the output register lets a new
// pixel request enter in the same cycle that a ray request leaves.
// Configuration registers should be written only while the pipeline is
// empty; the derived coefficients follow a write in the next cycle.
module pixel_to_undistorted_ray_core import p2ur_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    p2ur_pixel_if.sink            i_pixel,
    p2ur_ray_if.source            o_ray
);

    localparam int W         = COORD_WIDTH;
    localparam int F         = W - 4;
    localparam int NS        = NEWTON_STEPS;
    localparam int PROD_W    = PIX_W + GAIN_W;
    localparam int PROD_FRAC = PIX_FRAC + GAIN_W;
    localparam int PSH_DN    = (F <= PROD_FRAC) ? PROD_FRAC - F : 0;
    localparam int PSH_UP    = (F > PROD_FRAC) ? F - PROD_FRAC : 0;
    localparam logic signed [W-1:0] ONE = {3'b000, 1'b1, {F{1'b0}}};

    // Configuration registers, all cleared by reset.
    logic [GAIN_W-1:0]     r_gain_col;
    logic [REG_W-1:0]      r_offset_col;
    logic [GAIN_W-1:0]     r_gain_row;
    logic [REG_W-1:0]      r_offset_row;
    logic [REG_W-1:0]      r_coef_square;
    logic [REG_W-1:0]      r_coef_cube;
    logic [REG_W-1:0]      r_coef_quartic;
    logic [CFG_DATA_W-1:0] r_lens_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_col     <= '0;
            r_offset_col   <= '0;
            r_gain_row     <= '0;
            r_offset_row   <= '0;
            r_coef_square  <= '0;
            r_coef_cube    <= '0;
            r_coef_quartic <= '0;
            r_lens_shift   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_COL:     r_gain_col     <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET_COL:   r_offset_col   <= i_cfg_data[REG_W-1:0];
                CFG_GAIN_ROW:     r_gain_row     <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET_ROW:   r_offset_row   <= i_cfg_data[REG_W-1:0];
                CFG_COEF_SQUARE:  r_coef_square  <= i_cfg_data[REG_W-1:0];
                CFG_COEF_CUBE:    r_coef_cube    <= i_cfg_data[REG_W-1:0];
                CFG_COEF_QUARTIC: r_coef_quartic <= i_cfg_data[REG_W-1:0];
                CFG_LENS_SHIFT:   r_lens_shift   <= i_cfg_data;
                default:          r_lens_shift   <= r_lens_shift;
            endcase
        end
    end

    // Register values brought into the internal Q4.F format. The derivative
    // coefficients are 3*k2, 4*k3 and 5*k4, each saturated.
    logic signed [W-1:0] r_off_col, r_off_row, r_sh_h, r_sh_v;
    logic signed [W-1:0] r_k2, r_k3, r_k4, r_d2, r_d3, r_d4;
    t_wide               k2w, k3w, k4w;

    always_comb begin
        k2w = sat_to(from_q28(r_coef_square, F), W);
        k3w = sat_to(from_q28(r_coef_cube, F), W);
        k4w = sat_to(from_q28(r_coef_quartic, F), W);
    end

    always_ff @(posedge i_clk) begin
        r_off_col <= W'(sat_to(from_q28(r_offset_col, F), W));
        r_off_row <= W'(sat_to(from_q28(r_offset_row, F), W));
        r_sh_h    <= W'(sat_to(from_q28(r_lens_shift[REG_W-1:0], F), W));
        r_sh_v    <= W'(sat_to(from_q28(r_lens_shift[2*REG_W-1:REG_W], F), W));
        r_k2      <= W'(k2w);
        r_k3      <= W'(k3w);
        r_k4      <= W'(k4w);
        r_d2      <= W'(sat_to(k2w + (k2w <<< 1), W));
        r_d3      <= W'(sat_to(k3w <<< 2, W));
        r_d4      <= W'(sat_to(k4w + (k4w <<< 2), W));
    end

    // The whole pipeline moves when the output register is empty or being read.
    logic r_out_vld;
    logic en;

    assign en            = !r_out_vld || o_ray.ready;
    assign i_pixel.ready = en;

    // Pixel times gain, exact.
    logic              r_s0_vld;
    logic [PROD_W-1:0] r_pc_prod, r_pr_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_pixel.valid;
        end
        if (en) begin
            r_pc_prod <= PROD_W'(i_pixel.pixel_col) * PROD_W'(r_gain_col);
            r_pr_prod <= PROD_W'(i_pixel.pixel_row) * PROD_W'(r_gain_row);
        end
    end

    // Truncate to Q.F, subtract the offset, saturate.
    function automatic logic signed [W-1:0] scale(input logic [PROD_W-1:0] p,
                                                  input logic signed [W-1:0] off);
        t_wide pw;
        pw = (t_wide'(p) >>> PSH_DN) <<< PSH_UP;
        return W'(sat_to(pw - t_wide'(off), W));
    endfunction

    logic                r_s1_vld;
    logic signed [W-1:0] r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
        if (en) begin
            r_y <= scale(r_pc_prod, r_off_col);
            r_z <= scale(r_pr_prod, r_off_row);
        end
    end

    // Squares of both coordinates; y and z ride along as side data.
    logic signed [W-1:0] sq_a [2];
    logic [2*W-1:0]      sq_mag [2];
    logic                sq_vld;
    logic [2*W-1:0]      sq_side;

    assign sq_a[0] = r_y;
    assign sq_a[1] = r_z;

    p2ur_mul_cell #(.W(W), .SW(2*W), .LANES(2)) u_square (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r_s1_vld), .i_side({r_y, r_z}),
        .i_a(sq_a), .i_b(sq_a), .o_vld(sq_vld), .o_side(sq_side), .o_mag(sq_mag));

    logic           r_s3_vld;
    logic [2*W-1:0] r_s3_side;
    logic [2*W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= sq_vld;
        end
        if (en) begin
            r_s3_side <= sq_side;
            r_sum     <= sq_mag[0] + sq_mag[1];
        end
    end

    // Radius: floor square root, two radicand bits per cell.
    logic           sr_vld  [W+1];
    logic [2*W-1:0] sr_side [W+1];
    logic [2*W-1:0] sr_s    [W+1];
    logic [W+1:0]   sr_rem  [W+1];
    logic [W-1:0]   sr_root [W+1];

    assign sr_vld[0]  = r_s3_vld;
    assign sr_side[0] = r_s3_side;
    assign sr_s[0]    = r_sum;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        p2ur_sqrt_cell #(.W(W), .SW(2*W)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_vld(sr_vld[g]), .i_side(sr_side[g]), .i_s(sr_s[g]), .i_rem(sr_rem[g]),
            .i_root(sr_root[g]),
            .o_vld(sr_vld[g+1]), .o_side(sr_side[g+1]), .o_s(sr_s[g+1]),
            .o_rem(sr_rem[g+1]), .o_root(sr_root[g+1]));
    end

    // Newton steps on the correction factor, seeded at one.
    logic                nt_vld  [NS+1];
    logic [2*W-1:0]      nt_side [NS+1];
    logic signed [W-1:0] nt_r    [NS+1];
    logic signed [W-1:0] nt_c    [NS+1];

    assign nt_vld[0]  = sr_vld[W];
    assign nt_side[0] = sr_side[W];
    assign nt_r[0]    = sr_root[W][W-1] ? {1'b0, {(W-1){1'b1}}} : $signed(sr_root[W]);
    assign nt_c[0]    = ONE;

    for (genvar g = 0; g < NS; g++) begin : g_newton
        p2ur_newton #(.W(W), .SW(2*W)) u_step (
            .i_clk, .i_rst_n, .i_en(en),
            .i_k2(r_k2), .i_k3(r_k3), .i_k4(r_k4), .i_d2(r_d2), .i_d3(r_d3), .i_d4(r_d4),
            .i_vld(nt_vld[g]), .i_side(nt_side[g]), .i_r(nt_r[g]), .i_c(nt_c[g]),
            .o_vld(nt_vld[g+1]), .o_side(nt_side[g+1]), .o_r(nt_r[g+1]),
            .o_c(nt_c[g+1]));
    end

    // Scale both coordinates by the factor; the lane signs travel as side data.
    logic signed [W-1:0] fa [2];
    logic signed [W-1:0] fb [2];
    logic [2*W-1:0]      f_mag [2];
    logic                f_vld;
    logic [1:0]          f_neg;

    assign fa[0] = nt_c[NS];
    assign fa[1] = nt_c[NS];
    assign fb[0] = $signed(nt_side[NS][2*W-1:W]);
    assign fb[1] = $signed(nt_side[NS][W-1:0]);

    p2ur_mul_cell #(.W(W), .SW(2), .LANES(2)) u_scale (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(nt_vld[NS]),
        .i_side({fa[1][W-1] ^ fb[1][W-1], fa[0][W-1] ^ fb[0][W-1]}),
        .i_a(fa), .i_b(fb), .o_vld(f_vld), .o_side(f_neg), .o_mag(f_mag));

    // Subtract the lens-centre shift.
    logic                r_f_vld;
    logic signed [W-1:0] r_fy, r_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= f_vld;
        end
        if (en) begin
            r_fy <= W'(sat_to(sat_to(qmul_fin(f_neg[0], t_wide'(f_mag[0]), F, W), W)
                              - t_wide'(r_sh_h), W));
            r_fz <= W'(sat_to(sat_to(qmul_fin(f_neg[1], t_wide'(f_mag[1]), F, W), W)
                              - t_wide'(r_sh_v), W));
        end
    end

    // Output register: back to Q4.28.
    logic signed [RAY_W-1:0] r_out_h, r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_f_vld;
        end
        if (en) begin
            r_out_h <= RAY_W'(to_q28(t_wide'(r_fy), F));
            r_out_v <= RAY_W'(to_q28(t_wide'(r_fz), F));
        end
    end

    assign o_ray.valid     = r_out_vld;
    assign o_ray.ray_horiz = r_out_h;
    assign o_ray.ray_vert  = r_out_v;

endmodule
